// ----- src/yags_pkg.sv -----
// yags predictor package: shared constants, mode and source codes
// no dependencies
`timescale 1ns / 1ps
package yags_pkg;
   localparam int CHOICE_ENTRIES_DEF = 4096;
   localparam int CACHE_SETS_DEF     = 512;
   localparam int CACHE_WAYS_DEF     = 2;
   localparam int PC_TAG_BITS_DEF    = 8;
   localparam int PC_W   = 32;
   localparam int SAVE_W = 10;
   localparam int CTR_W  = 4;

   typedef enum logic [2:0] {
      MODE_LOOKUP = 3'd0,
      MODE_UNCOND = 3'd1,
      MODE_UPDATE = 3'd2,
      MODE_SQUASH = 3'd3,
      MODE_BTB    = 3'd4
   } mode_type;

   localparam logic [1:0] SRC_CHOICE = 2'd0;
   localparam logic [1:0] SRC_TAKEN  = 2'd1;
   localparam logic [1:0] SRC_NTAKEN = 2'd2;

   localparam logic [1:0] CSR_SHIFT  = 2'd0;
   localparam logic [1:0] CSR_CHOICE = 2'd1;
   localparam logic [1:0] CSR_CACHE  = 2'd2;

   function automatic logic [2:0] eff_bits(input logic [2:0] b);
      if (b == 3'd0) return 3'd1;
      if (b > 3'd4) return 3'd4;
      return b;
   endfunction

   function automatic logic [CTR_W-1:0] ctr_max(input logic [2:0] b);
      logic [4:0] v;
      v = (5'd1 << eff_bits(b)) - 5'd1;
      return v[CTR_W-1:0];
   endfunction

   function automatic logic [CTR_W-1:0] ctr_thr(input logic [2:0] b);
      logic [4:0] v;
      v = (5'd1 << (eff_bits(b) - 3'd1)) - 5'd1;
      return v[CTR_W-1:0];
   endfunction

   function automatic logic [CTR_W-1:0] ctr_train(input logic [CTR_W-1:0] c,
                                                  input logic up,
                                                  input logic [2:0] b);
      if (up) return (c < ctr_max(b)) ? c + 1'b1 : c;
      return (c != '0) ? c - 1'b1 : c;
   endfunction
endpackage

// ----- src/yags_branch_predictor_top.sv -----
// yags branch predictor top level: choice table and two tagged exception caches
// depends on yags_pkg
`timescale 1ns / 1ps
// usage
//  req channel carries one transaction per lookup, unconditional branch, update,
//  squash or btb update; rsp channel returns one transaction for each request
//  (zero fields for modes without a prediction).
//  each request walks through accept, a synchronous memory read, then a
//  read-modify-write step that writes choice and cache entries back and
//  registers the response. the next request is accepted only once the
//  response has been taken, so no new request is taken while one is in
//  flight; the single memory read port per table and the one response
//  register set this.
//  after reset a clearing pass walks every choice entry and cache set, one a
//  cycle; no request is accepted then, csr writes are taken at any time.
//  when rsp_tready is low the response is held and req_tready stays low.
module yags_branch_predictor_top #(
   parameter int CHOICE_ENTRIES = yags_pkg::CHOICE_ENTRIES_DEF,
   parameter int CACHE_SETS     = yags_pkg::CACHE_SETS_DEF,
   parameter int CACHE_WAYS     = yags_pkg::CACHE_WAYS_DEF,
   parameter int PC_TAG_BITS    = yags_pkg::PC_TAG_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[2:0], pc[34:3], outcome_taken[35], was_squashed[36],
   // saved_history[46:37], saved_source[48:47], saved_prediction[49], zero pad
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // predict_taken[0], history_snapshot[10:1], source_used[12:11], zero pad
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [2:0]  csr_wdata
);
   localparam int CI_W  = $clog2(CHOICE_ENTRIES);
   localparam int SI_W  = $clog2(CACHE_SETS);
   localparam int WL    = $clog2(CACHE_WAYS);
   localparam int HB    = $clog2(CACHE_SETS * CACHE_WAYS);
   localparam int TAG_W = (PC_TAG_BITS > HB + WL) ? PC_TAG_BITS : HB + WL;
   localparam int RK_W  = (WL < 1) ? 1 : WL;
   localparam int CLR_N = (CHOICE_ENTRIES > CACHE_SETS) ? CHOICE_ENTRIES : CACHE_SETS;
   localparam int CLR_W = $clog2(CLR_N) + 1;
   localparam int SW    = yags_pkg::SAVE_W;
   localparam int CW    = yags_pkg::CTR_W;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [CW-1:0]    ctr;
      logic [RK_W-1:0]  rank;
   } way_type;
   typedef way_type [CACHE_WAYS-1:0] set_type;
   typedef struct packed {
      set_type        ways;
      logic [RK_W-1:0] victim;
   } row_type;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_RMW} state_type;

   logic [CW-1:0] choice_mem [CHOICE_ENTRIES];
   row_type       tk_mem [CACHE_SETS];
   row_type       nt_mem [CACHE_SETS];

   state_type         state_ff;
   logic [CLR_W-1:0]  clr_ff;
   logic [HB-1:0]     hist_ff;
   logic [1:0]        shift_ff;
   logic [2:0]        cbits_ff, kbits_ff;
   logic [2:0]        mode_ff;
   logic              taken_ff, squash_ff, spred_ff;
   logic [SW-1:0]     saved_ff;
   logic [1:0]        src_ff;
   logic [CI_W-1:0]   ci_ff;
   logic [SI_W-1:0]   si_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [CW-1:0]     crd_ff;
   row_type           tkrd_ff, ntrd_ff;
   logic              rsp_valid_ff;
   logic [15:0]       rsp_data_ff;

   logic [2:0]  in_mode;
   logic [31:0] in_spc;
   logic [SW-1:0] in_saved;
   logic [HB-1:0] in_hist;
   logic [31:0] in_sx;
   logic [HB-1:0] top_mask;

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign in_mode  = req_tdata[2:0];
   assign in_spc   = req_tdata[34:3] >> shift_ff;
   assign in_saved = req_tdata[46:37];
   assign in_hist  = (in_mode == yags_pkg::MODE_LOOKUP) ? hist_ff : in_saved[HB-1:0];
   assign in_sx    = in_spc ^ 32'(in_hist);
   assign top_mask = {HB{1'b1}} - ({HB{1'b1}} >> WL);

   // rmw logic
   row_type       tk_new, nt_new, sel_row, tr_row;
   logic [CW-1:0] c_new;
   logic          c_we, tk_we, nt_we;
   logic          bias, pred, hit;
   logic [1:0]    used;
   logic [RK_W-1:0] old_rank;
   logic          train_tk, train_nt, do_choice, choice_up;
   logic [HB-1:0] hist_new;

   function automatic row_type touch_row(input row_type r, input int w);
      row_type o;
      logic [RK_W-1:0] old;
      o = r;
      old = r.ways[w].rank;
      o.ways[w].rank = RK_W'(CACHE_WAYS - 1);
      for (int c = 0; c < CACHE_WAYS; c++) begin
         if (o.ways[c].rank > old && c != w) o.ways[c].rank = o.ways[c].rank - 1'b1;
         if (o.ways[c].rank == '0) o.victim = RK_W'(c);
      end
      return o;
   endfunction

   function automatic row_type train_row(input row_type r, input logic [TAG_W-1:0] t,
                                         input logic up, input logic [2:0] b);
      row_type o;
      logic h;
      logic [RK_W-1:0] v;
      o = r;
      h = 1'b0;
      for (int w = 0; w < CACHE_WAYS; w++) begin
         if (r.ways[w].tag == t) begin
            o = touch_row(o, w);
            o.ways[w].ctr = yags_pkg::ctr_train(o.ways[w].ctr, up, b);
            h = 1'b1;
         end
      end
      if (!h) begin
         v = RK_W'(32'(r.victim) % CACHE_WAYS);
         o.ways[v].tag = t;
         o.ways[v].ctr = yags_pkg::ctr_train('0, up, b);
      end
      return o;
   endfunction

   always_comb begin
      tk_new = tkrd_ff;
      nt_new = ntrd_ff;
      c_new = crd_ff;
      c_we = 1'b0; tk_we = 1'b0; nt_we = 1'b0;
      pred = 1'b0; used = yags_pkg::SRC_CHOICE; hit = 1'b0;
      old_rank = '0;
      train_tk = 1'b0; train_nt = 1'b0; do_choice = 1'b0; choice_up = taken_ff;
      hist_new = hist_ff;
      bias = crd_ff > yags_pkg::ctr_thr(cbits_ff);
      sel_row = bias ? tkrd_ff : ntrd_ff;
      tr_row = sel_row;
      unique case (mode_ff)
         yags_pkg::MODE_LOOKUP: begin
            pred = bias;
            for (int w = CACHE_WAYS - 1; w >= 0; w--) begin
               if (sel_row.ways[w].tag == tag_ff) begin
                  hit = 1'b1;
                  old_rank = RK_W'(w);
               end
            end
            if (hit) begin
               tr_row = touch_row(sel_row, int'(old_rank));
               pred = sel_row.ways[old_rank].ctr > yags_pkg::ctr_thr(kbits_ff);
               used = bias ? yags_pkg::SRC_TAKEN : yags_pkg::SRC_NTAKEN;
               if (bias) begin tk_new = tr_row; tk_we = 1'b1; end
               else begin nt_new = tr_row; nt_we = 1'b1; end
            end
            hist_new = {hist_ff[HB-2:0], pred};
         end
         yags_pkg::MODE_UNCOND: begin
            pred = 1'b1;
            hist_new = {hist_ff[HB-2:0], 1'b1};
         end
         yags_pkg::MODE_UPDATE: begin
            case (src_ff)
               yags_pkg::SRC_CHOICE: begin
                  do_choice = 1'b1;
                  if (spred_ff != taken_ff) begin
                     train_tk = taken_ff;
                     train_nt = !taken_ff;
                  end
               end
               yags_pkg::SRC_TAKEN: begin
                  do_choice = !(taken_ff && spred_ff);
                  train_tk = 1'b1;
               end
               yags_pkg::SRC_NTAKEN: begin
                  do_choice = !(!taken_ff && !spred_ff);
                  train_nt = 1'b1;
               end
               default: ;
            endcase
            if (do_choice) begin
               c_new = yags_pkg::ctr_train(crd_ff, choice_up, cbits_ff);
               c_we = 1'b1;
            end
            if (train_tk) begin
               tk_new = train_row(tkrd_ff, tag_ff, taken_ff, kbits_ff); tk_we = 1'b1;
            end
            if (train_nt) begin
               nt_new = train_row(ntrd_ff, tag_ff, taken_ff, kbits_ff); nt_we = 1'b1;
            end
            if (squash_ff) hist_new = {saved_ff[HB-2:0], taken_ff};
         end
         yags_pkg::MODE_SQUASH: hist_new = saved_ff[HB-1:0];
         yags_pkg::MODE_BTB:    hist_new = {hist_ff[HB-1:1], 1'b0};
         default: ;
      endcase
   end

   row_type clr_row;
   always_comb begin
      clr_row = '0;
      for (int w = 0; w < CACHE_WAYS; w++) clr_row.ways[w].rank = RK_W'(w);
   end

   // memories
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         if (clr_ff < CLR_W'(CHOICE_ENTRIES)) choice_mem[clr_ff[CI_W-1:0]] <= '0;
         if (clr_ff < CLR_W'(CACHE_SETS)) begin
            tk_mem[clr_ff[SI_W-1:0]] <= clr_row;
            nt_mem[clr_ff[SI_W-1:0]] <= clr_row;
         end
      end else if (state_ff == ST_RMW) begin
         if (c_we)  choice_mem[ci_ff] <= c_new;
         if (tk_we) tk_mem[si_ff] <= tk_new;
         if (nt_we) nt_mem[si_ff] <= nt_new;
      end
      if (state_ff == ST_READ) begin
         crd_ff  <= choice_mem[ci_ff];
         tkrd_ff <= tk_mem[si_ff];
         ntrd_ff <= nt_mem[si_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         hist_ff <= '0;
         shift_ff <= 2'd2;
         cbits_ff <= 3'd2;
         kbits_ff <= 3'd2;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               yags_pkg::CSR_SHIFT:  shift_ff <= csr_wdata[1:0];
               yags_pkg::CSR_CHOICE: cbits_ff <= csr_wdata;
               yags_pkg::CSR_CACHE:  kbits_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLR_W'(CLR_N - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: if (req_tvalid && req_tready) state_ff <= ST_READ;
            ST_READ: state_ff <= ST_RMW;
            ST_RMW: begin
               hist_ff <= hist_new;
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         mode_ff   <= in_mode;
         taken_ff  <= req_tdata[35];
         squash_ff <= req_tdata[36];
         saved_ff  <= in_saved;
         src_ff    <= req_tdata[48:47];
         spred_ff  <= req_tdata[49];
         ci_ff     <= in_spc[CI_W-1:0];
         si_ff     <= in_sx[SI_W-1:0];
         tag_ff    <= TAG_W'(in_spc[PC_TAG_BITS-1:0]) | (TAG_W'(in_hist & top_mask) << WL);
      end
      if (state_ff == ST_RMW) begin
         if (mode_ff == yags_pkg::MODE_LOOKUP || mode_ff == yags_pkg::MODE_UNCOND)
            rsp_data_ff <= {3'b000, used, SW'(hist_ff), pred};
         else
            rsp_data_ff <= '0;
      end
   end
endmodule

// ----- src/yags_checker.sv -----
// port checker for the yags branch predictor top level
// depends on yags_branch_predictor_top ports
`timescale 1ns / 1ps
module yags_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   a_no_accept_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken with response pending");
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> ##2 rsp_tvalid) else $error("response late");
   a_no_ready_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("back to back accept");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");
   a_src_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[12:11] != 2'd3) else $error("bad source code");
endmodule

bind yags_branch_predictor_top yags_checker u_yags_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// ----- dv/yags_branch_predictor_top_tb.sv -----
// testbench for yags_branch_predictor_top: directed and random requests checked
// against a behavioral predictor of choice table, exception caches and history
// depends on yags_pkg and yags_branch_predictor_top
`timescale 1ns / 1ps
module yags_branch_predictor_top_tb;
   localparam int SETS = yags_pkg::CACHE_SETS_DEF;
   localparam int WAYS = yags_pkg::CACHE_WAYS_DEF;
   localparam int CHOICES = yags_pkg::CHOICE_ENTRIES_DEF;
   localparam int HB = $clog2(SETS * WAYS);
   localparam int WL = $clog2(WAYS);
   localparam logic [HB-1:0] HMASK = '1;

   typedef struct packed {
      logic       pred_prev;
      logic [1:0] source;
      logic [9:0] hist;
      logic       squashed;
      logic       taken;
      logic [31:0] pc;
      logic [2:0] mode;
   } branch_req_type;

   typedef struct packed {
      logic [1:0] source;
      logic [9:0] snapshot;
      logic       predict;
   } branch_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [55:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic csr_we = 0;
   logic [1:0] csr_index = yags_pkg::CSR_SHIFT;
   logic [2:0] csr_wdata = '0;
   logic in_accepted = 0;

   yags_branch_predictor_top i_dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // predictor state
   logic [1:0] shift_amt;
   logic [2:0] choice_bits, cache_bits;
   logic [HB-1:0] ghist;
   logic [3:0] choice_ctr [CHOICES];
   logic [10:0] tags [2][SETS][WAYS];
   logic [3:0] ctrs [2][SETS][WAYS];
   int unsigned ranks [2][SETS][WAYS];
   int unsigned victim [2][SETS];

   branch_req_type pending_reqs [$];
   branch_rsp_type expected_rsps [$];
   int send_idle_pct = 26, recv_idle_pct = 73;
   int mismatches = 0;

   function automatic logic [3:0] eff(input logic [2:0] b);
      return (b == 0) ? 4'd1 : (b > 4) ? 4'd4 : {1'b0, b};
   endfunction

   function automatic logic [3:0] sat_step(input logic [3:0] c, input logic up,
                                           input logic [2:0] b);
      logic [4:0] top;
      top = (5'd1 << eff(b)) - 5'd1;
      if (up) return ({1'b0, c} < top) ? c + 4'd1 : c;
      return (c != 0) ? c - 4'd1 : c;
   endfunction

   function automatic logic is_taken(input logic [3:0] c, input logic [2:0] b);
      logic [4:0] thr;
      thr = (5'd1 << (eff(b) - 4'd1)) - 5'd1;
      return {1'b0, c} > thr;
   endfunction

   function automatic logic [10:0] form_tag(input logic [31:0] spc, input logic [HB-1:0] h);
      logic [HB-1:0] top;
      top = HMASK - (HMASK >> WL);
      return 11'(spc[yags_pkg::PC_TAG_BITS_DEF-1:0]) | (11'(h & top) << WL);
   endfunction

   task automatic touch_way(input int k, input int s, input int w);
      int unsigned old;
      old = ranks[k][s][w];
      ranks[k][s][w] = WAYS - 1;
      for (int c = 0; c < WAYS; c++) begin
         if (ranks[k][s][c] > old && c != w) ranks[k][s][c]--;
         if (ranks[k][s][c] == 0) victim[k][s] = c;
      end
   endtask

   task automatic train_exception(input int k, input int s, input logic [10:0] tg,
                                  input logic tk);
      bit hit;
      int v;
      hit = 0;
      for (int w = 0; w < WAYS; w++)
         if (tags[k][s][w] == tg) begin
            touch_way(k, s, w);
            ctrs[k][s][w] = sat_step(ctrs[k][s][w], tk, cache_bits);
            hit = 1;
         end
      if (!hit) begin
         v = victim[k][s] % WAYS;
         tags[k][s][v] = tg;
         ctrs[k][s][v] = sat_step(4'd0, tk, cache_bits);
      end
   endtask

   task automatic predict_branch(input branch_req_type r);
      branch_rsp_type e;
      logic [31:0] spc;
      int ci, si, k;
      logic [10:0] tg;
      logic bias, pred;
      logic [HB-1:0] h;
      e = '0;
      spc = r.pc >> shift_amt;
      ci = spc % CHOICES;
      if (r.mode == yags_pkg::MODE_LOOKUP) begin
         si = (spc ^ 32'(ghist)) % SETS;
         tg = form_tag(spc, ghist);
         bias = is_taken(choice_ctr[ci], choice_bits);
         pred = bias;
         k = bias ? 0 : 1;
         for (int w = 0; w < WAYS; w++)
            if (tags[k][si][w] == tg) begin
               touch_way(k, si, w);
               pred = is_taken(ctrs[k][si][w], cache_bits);
               e.source = bias ? yags_pkg::SRC_TAKEN : yags_pkg::SRC_NTAKEN;
               break;
            end
         e.predict = pred;
         e.snapshot = 10'(ghist);
         ghist = {ghist[HB-2:0], pred};
      end else if (r.mode == yags_pkg::MODE_UNCOND) begin
         e.predict = 1;
         e.snapshot = 10'(ghist);
         ghist = {ghist[HB-2:0], 1'b1};
      end else if (r.mode == yags_pkg::MODE_UPDATE) begin
         h = r.hist[HB-1:0];
         si = (spc ^ 32'(h)) % SETS;
         tg = form_tag(spc, h);
         if (r.source == yags_pkg::SRC_CHOICE) begin
            if (r.pred_prev != r.taken) train_exception(r.taken ? 0 : 1, si, tg, r.taken);
            choice_ctr[ci] = sat_step(choice_ctr[ci], r.taken, choice_bits);
         end else if (r.source == yags_pkg::SRC_TAKEN) begin
            if (!(r.taken && r.pred_prev))
               choice_ctr[ci] = sat_step(choice_ctr[ci], r.taken, choice_bits);
            train_exception(0, si, tg, r.taken);
         end else if (r.source == yags_pkg::SRC_NTAKEN) begin
            if (!(!r.taken && !r.pred_prev))
               choice_ctr[ci] = sat_step(choice_ctr[ci], r.taken, choice_bits);
            train_exception(1, si, tg, r.taken);
         end
         if (r.squashed) ghist = {h[HB-2:0], r.taken};
      end else if (r.mode == yags_pkg::MODE_SQUASH) begin
         ghist = r.hist[HB-1:0];
      end else if (r.mode == yags_pkg::MODE_BTB) begin
         ghist[0] = 1'b0;
      end
      expected_rsps.push_back(e);
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (in_accepted) begin
            predict_branch(branch_req_type'(req_tdata[49:0]));
            void'(pending_reqs.pop_front());
         end
         if (!(req_tvalid && !in_accepted)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1;
               req_tdata <= {6'd0, pending_reqs[0]};
            end else begin
               req_tvalid <= 0;
            end
         end
         rsp_tready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // monitor
   always @(posedge clock) begin
      branch_rsp_type got, e;
      in_accepted <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = branch_rsp_type'(rsp_tdata[12:0]);
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %h", got);
         end else begin
            e = expected_rsps.pop_front();
            if (got.predict !== e.predict || got.snapshot !== e.snapshot ||
                got.source !== e.source) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected pred %b hist %h src %0d, got %b %h %0d",
                           e.predict, e.snapshot, e.source,
                           got.predict, got.snapshot, got.source);
            end
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [2:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      if (idx == yags_pkg::CSR_SHIFT) shift_amt = val[1:0];
      else if (idx == yags_pkg::CSR_CHOICE) choice_bits = val;
      else cache_bits = val;
   endtask

   task automatic drain;
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // random mix of lookups, updates, unconditional, squash, btb and unused mode codes
   function automatic branch_req_type rand_req();
      branch_req_type r;
      int sel;
      r = 50'({$urandom, $urandom});
      sel = $urandom_range(99);
      if (sel < 40) r.mode = yags_pkg::MODE_LOOKUP;
      else if (sel < 75) r.mode = yags_pkg::MODE_UPDATE;
      else if (sel < 82) r.mode = yags_pkg::MODE_UNCOND;
      else if (sel < 88) r.mode = yags_pkg::MODE_SQUASH;
      else if (sel < 94) r.mode = yags_pkg::MODE_BTB;
      else r.mode = 3'($urandom_range(7));
      if ($urandom_range(3) != 0) r.pc = {4'($urandom_range(15)), 24'd0, 4'($urandom)} |
                                         32'($urandom_range(63) << 2);
      if (r.mode == yags_pkg::MODE_UPDATE && $urandom_range(3) != 0)
         r.hist = 10'($urandom_range(7));
      r.squashed = ($urandom_range(4) == 0);
      return r;
   endfunction

   task automatic run_phase(input int n);
      for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
      drain();
   endtask

   initial begin
      branch_req_type r;
      shift_amt = 2; choice_bits = 2; cache_bits = 2; ghist = '0;
      foreach (choice_ctr[i]) choice_ctr[i] = '0;
      for (int k = 0; k < 2; k++)
         for (int s = 0; s < SETS; s++) begin
            victim[k][s] = 0;
            for (int w = 0; w < WAYS; w++) begin
               tags[k][s][w] = '0; ctrs[k][s][w] = '0; ranks[k][s][w] = w;
            end
         end
      repeat (3) @(posedge clock);
      reset <= 0;
      // directed: every mode, extremes, duplicate-tag and unused-source cases
      for (int i = 0; i < 24; i++) begin
         r = '0;
         r.mode = 3'(i % 8);
         r.pc = (i % 3 == 0) ? 32'hFFFF_FFFF : (i % 3 == 1) ? 32'h0 : 32'h40;
         r.taken = i[0];
         r.pred_prev = i[1];
         r.source = 2'(i / 6);
         r.squashed = (i % 5 == 0);
         r.hist = (i % 4 == 0) ? 10'h3FF : 10'h0;
         pending_reqs.push_back(r);
      end
      drain();
      write_csr(yags_pkg::CSR_SHIFT, 3'd0);
      write_csr(yags_pkg::CSR_CHOICE, 3'd1);
      write_csr(yags_pkg::CSR_CACHE, 3'd4);
      run_phase(250);
      send_idle_pct = 73; recv_idle_pct = 26;
      write_csr(yags_pkg::CSR_SHIFT, 3'd3);
      write_csr(yags_pkg::CSR_CHOICE, 3'd0);
      write_csr(yags_pkg::CSR_CACHE, 3'd7);
      run_phase(250);
      send_idle_pct = 0; recv_idle_pct = 0;
      write_csr(yags_pkg::CSR_SHIFT, 3'd1);
      write_csr(yags_pkg::CSR_CHOICE, 3'd4);
      write_csr(yags_pkg::CSR_CACHE, 3'd1);
      run_phase(175);
      write_csr(yags_pkg::CSR_SHIFT, 3'd2);
      write_csr(yags_pkg::CSR_CHOICE, 3'd6);
      write_csr(yags_pkg::CSR_CACHE, 3'd0);
      run_phase(175);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end
endmodule

// ----- files.f -----
src/yags_pkg.sv
src/yags_branch_predictor_top.sv
src/yags_checker.sv
dv/yags_branch_predictor_top_tb.sv
